/* design/sscm_pkg.sv */
package sscm_pkg;

    // Store geometry and timestamp width
    localparam int MAX_ENTRIES = 1024;
    localparam int TIME_BITS   = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int POS_W       = $clog2(MAX_ENTRIES + 1);

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command codes on the input channel
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_RESTART
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic [IDX_W-1:0]            index;
        logic signed [TIME_BITS-1:0] value;
    } t_item;

    // Back-end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RESULT
    } t_back_state;

endpackage

/* design/sorted_series_cross_match_unit.sv */
// Sorted series cross match unit.
// Input channel (i_valid/o_ready) carries a command with an entry index and a
// timestamp: write a reference entry, query a timestamp, or restart the scan
// cursor. Only a query gives a result, on the output channel (o_valid/i_ready)
// as the 1-based position of the first stored entry at or above the query
// timestamp, or 0 if none lies between the cursor and the end of the series.
// i_cfg_we/i_cfg_wdata set the series length; write it while the unit is idle.
// Transfers enter a four-deep command queue; the back end retires one write
// or restart per cycle while it is not busy with a query. A query occupies
// the back end for a pop step that issues the first read, one compare per
// cycle against the single-port reference store with the next read issued
// alongside, and a result step. A query that scans nothing has only the pop
// and result steps. Because the cursor only moves forward between restarts,
// scan work over a series is bounded by the queries plus the entries.
// A stalled receiver holds the output register; the back end then waits in
// its result state while the queue keeps taking transfers until it fills.
// Synchronous reset clears the cursor, the series length, the queue and the
// output valid; the store contents are kept and are undefined until written.
module sorted_series_cross_match_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sscm_pkg::POS_W-1:0]            i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_command,
    input  logic [sscm_pkg::IDX_W-1:0]            i_entry_index,
    input  logic signed [sscm_pkg::TIME_BITS-1:0] i_time_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [sscm_pkg::POS_W-1:0]            o_match_position
);

    logic            push;
    logic            q_ready;
    logic            q_valid;
    logic            pop;
    sscm_pkg::t_item push_item;
    sscm_pkg::t_item pop_item;

    sscm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_time_value  (i_time_value),
        .o_push        (push),
        .o_item        (push_item),
        .i_q_ready     (q_ready)
    );

    sscm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (pop_item),
        .i_pop   (pop)
    );

    sscm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_q_valid        (q_valid),
        .i_q_item         (pop_item),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_match_position (o_match_position)
    );

endmodule

/* design/sscm_front.sv */
module sscm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_command,
    input  logic [sscm_pkg::IDX_W-1:0]            i_entry_index,
    input  logic signed [sscm_pkg::TIME_BITS-1:0] i_time_value,
    output logic                                  o_push,
    output sscm_pkg::t_item                       o_item,
    input  logic                                  i_q_ready
);

    logic r_seen_unused;
    logic n_seen_unused;
    logic keep;

    // Accept whenever the queue has room
    assign o_ready = i_q_ready;

    // Decode the command; the unused code is taken and dropped
    always_comb begin
        o_item.index = i_entry_index;
        o_item.value = i_time_value;
        o_item.op    = sscm_pkg::OP_WRITE;
        keep         = 1'b1;
        unique case (i_command)
            sscm_pkg::CMD_WRITE:   o_item.op = sscm_pkg::OP_WRITE;
            sscm_pkg::CMD_QUERY:   o_item.op = sscm_pkg::OP_QUERY;
            sscm_pkg::CMD_RESTART: o_item.op = sscm_pkg::OP_RESTART;
            sscm_pkg::CMD_UNUSED:  keep = 1'b0;
            default:               keep = 1'b0;
        endcase
    end

    assign o_push = i_valid && i_q_ready && keep;

    // Sticky flag of dropped transfers, kept for debug visibility
    assign n_seen_unused = r_seen_unused | (i_valid && i_q_ready && !keep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_unused <= 1'b0;
        end else begin
            r_seen_unused <= n_seen_unused;
        end
    end

endmodule

/* design/sscm_queue.sv */
module sscm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sscm_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output sscm_pkg::t_item o_item,
    input  logic            i_pop
);

    sscm_pkg::t_item                r_slot [sscm_pkg::Q_DEPTH];
    logic [sscm_pkg::Q_PTR_W-1:0]   r_wptr;
    logic [sscm_pkg::Q_PTR_W-1:0]   r_rptr;
    logic [sscm_pkg::Q_CNT_W-1:0]   r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_ready = (r_count != sscm_pkg::Q_CNT_W'(sscm_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

/* design/sscm_back.sv */
module sscm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sscm_pkg::POS_W-1:0]       i_cfg_wdata,
    input  logic                             i_q_valid,
    input  sscm_pkg::t_item                  i_q_item,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sscm_pkg::POS_W-1:0]       o_match_position
);

    localparam logic [sscm_pkg::POS_W-1:0] MaxN = sscm_pkg::POS_W'(sscm_pkg::MAX_ENTRIES);

    sscm_pkg::t_back_state r_state;
    sscm_pkg::t_back_state n_state;

    logic [sscm_pkg::POS_W-1:0]          r_ref_count;
    logic [sscm_pkg::POS_W-1:0]          r_cursor;
    logic [sscm_pkg::POS_W-1:0]          n_cursor;
    logic signed [sscm_pkg::TIME_BITS-1:0] r_key;
    logic signed [sscm_pkg::TIME_BITS-1:0] n_key;
    logic [sscm_pkg::POS_W-1:0]          r_pos;
    logic [sscm_pkg::POS_W-1:0]          n_pos;
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic [sscm_pkg::POS_W-1:0]          r_out_pos;
    logic [sscm_pkg::POS_W-1:0]          n_out_pos;

    logic signed [sscm_pkg::TIME_BITS-1:0] r_mem [sscm_pkg::MAX_ENTRIES];
    logic signed [sscm_pkg::TIME_BITS-1:0] r_rd_data;

    logic [sscm_pkg::POS_W-1:0] eff_n;
    logic [sscm_pkg::POS_W-1:0] cursor_inc;
    logic                       at_end;
    logic                       inc_end;
    logic                       hit;
    logic                       mem_we;
    logic                       rd_en;
    logic [sscm_pkg::IDX_W-1:0] rd_addr;
    logic                       out_load;

    // Series length, clipped to the store depth
    assign eff_n      = (r_ref_count > MaxN) ? MaxN : r_ref_count;
    assign cursor_inc = r_cursor + 1'b1;
    assign at_end     = (r_cursor >= eff_n);
    assign inc_end    = (cursor_inc >= eff_n);
    assign hit        = (r_rd_data >= r_key);
    assign o_pop      = (r_state == sscm_pkg::ST_IDLE) && i_q_valid;
    assign out_load   = (r_state == sscm_pkg::ST_RESULT) && (!r_out_valid || i_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sscm_pkg::ST_IDLE: begin
                if (i_q_valid && i_q_item.op == sscm_pkg::OP_QUERY) begin
                    n_state = at_end ? sscm_pkg::ST_RESULT : sscm_pkg::ST_CMP;
                end
            end
            sscm_pkg::ST_CMP: begin
                if (hit || inc_end) begin
                    n_state = sscm_pkg::ST_RESULT;
                end
            end
            sscm_pkg::ST_RESULT: begin
                if (out_load) begin
                    n_state = sscm_pkg::ST_IDLE;
                end
            end
            default: n_state = sscm_pkg::ST_IDLE;
        endcase
    end

    // Datapath control: one compare per cycle, next read issued alongside
    always_comb begin
        n_cursor = r_cursor;
        n_key    = r_key;
        n_pos    = r_pos;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_cursor[sscm_pkg::IDX_W-1:0];
        unique case (r_state)
            sscm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        sscm_pkg::OP_WRITE:   mem_we = 1'b1;
                        sscm_pkg::OP_RESTART: n_cursor = '0;
                        sscm_pkg::OP_QUERY: begin
                            n_key = i_q_item.value;
                            if (at_end) begin
                                n_pos    = '0;
                                n_cursor = eff_n;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sscm_pkg::ST_CMP: begin
                if (hit) begin
                    n_pos = cursor_inc;
                end else if (inc_end) begin
                    n_pos    = '0;
                    n_cursor = eff_n;
                end else begin
                    n_cursor = cursor_inc;
                    rd_en    = 1'b1;
                    rd_addr  = cursor_inc[sscm_pkg::IDX_W-1:0];
                end
            end
            sscm_pkg::ST_RESULT: ;
            default: ;
        endcase
    end

    // Output register: frees the back end while the receiver stalls
    assign n_out_valid = out_load || (r_out_valid && !i_ready);
    assign n_out_pos   = out_load ? r_pos : r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sscm_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_ref_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_ref_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_pos     <= n_pos;
        r_out_pos <= n_out_pos;
    end

    // Reference store, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_item.index] <= i_q_item.value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_valid          = r_out_valid;
    assign o_match_position = r_out_pos;

endmodule
